// ----- src/fjb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_pkg
// shared constants and types of the frame jitter buffer selector
// ----------------------------------------------------------------------------
package fjb_pkg;

   localparam int MAX_FRAMES = 32;
   localparam int KEY_W      = 31;
   localparam int CNT_W      = $clog2(MAX_FRAMES + 2);
   localparam int ADDR_W     = $clog2(MAX_FRAMES + 1) + 1;
   localparam int DEPTH      = 2 ** ADDR_W;
   localparam int CAP_W      = 6;
   localparam int DLY_W      = 10;
   localparam int PLAYED_W   = 7;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DONE   = 2'd1;
   localparam logic [1:0] CMD_RESYNC = 2'd2;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_DELAY    = 2'd1;

   localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(15);
   localparam logic [DLY_W-1:0]    DLY_RESET    = DLY_W'(30);
   localparam logic [DLY_W-1:0]    DLY_CAP      = DLY_W'(10);
   localparam logic [PLAYED_W-1:0] PLAYED_LIMIT = PLAYED_W'(100);
   localparam logic [CNT_W-1:0]    MIN_SELECT   = CNT_W'(3);
   localparam logic [CNT_W-1:0]    BACK_OFFSET  = CNT_W'(6);

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic              we;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [DLY_W-1:0] delay_frames;
   } cfg_type;

endpackage
`default_nettype wire

// ----- src/frame_jitter_buffer_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_jitter_buffer_selector
// sorted frame number set with playout frame selection
// ----------------------------------------------------------------------------
// usage
//   req_ carries one command word: add, decode done or resync. each word
//   yields exactly one rsp_ word with the issued frame, fill count and the
//   current playback frame. csr_ writes capacity (index 0) and delay (1);
//   the user must write them only while the block is idle, it does not enforce it.
// timing
//   the keys sit in a single-port-per-direction memory and every walk reads
//   a key through its registered read port and uses it in the next state.
//   an add with data searches, shifts (unless the frame is already held)
//   and runs the selection scan, decode done the selection scan and a resync
//   a filtering pass. req_stall is high while a word is being worked on.
// reset
//   synchronous; clears the set, playback state and restores the registers.
// stall
//   the result waits in an output register; the next request is taken but
//   its result is held back until the previous word is taken.
// ----------------------------------------------------------------------------
module frame_jitter_buffer_selector (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [1:0]                 req_cmd,
   input  wire  [30:0]                req_frame_number,
   input  wire                        req_data_present,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic                       rsp_play_valid,
   output logic [30:0]                rsp_play_frame,
   output logic [5:0]                 rsp_fill_count,
   output logic signed [31:0]         rsp_current_frame,
   input  wire                        csr_we,
   input  wire  [1:0]                 csr_index,
   input  wire  [9:0]                 csr_wdata
);
   import fjb_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   mem_req_type      mem_req;
   logic [KEY_W-1:0] rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: cfg_in.capacity     = csr_wdata[CAP_W-1:0];
            CSR_DELAY:    cfg_in.delay_frames = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity     <= CAP_RESET;
         cfg_ff.delay_frames <= DLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fjb_key_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fjb_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_frame_number  (req_frame_number),
      .req_data_present  (req_data_present),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_play_valid    (rsp_play_valid),
      .rsp_play_frame    (rsp_play_frame),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_current_frame (rsp_current_frame),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

endmodule
`default_nettype wire

// ----- src/fjb_key_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_key_store
// frame number memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fjb_key_store (
   input  wire                        clock,
   input  fjb_pkg::mem_req_type       mem_req,
   output logic [fjb_pkg::KEY_W-1:0]  rd_data
);
   import fjb_pkg::*;

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/fjb_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_seq
// sequencer walking the sorted key set for insert, selection and resync
// ----------------------------------------------------------------------------
module fjb_seq (
   input  wire                           clock,
   input  wire                           reset,
   input  fjb_pkg::cfg_type              cfg,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [1:0]                    req_cmd,
   input  wire  [fjb_pkg::KEY_W-1:0]     req_frame_number,
   input  wire                           req_data_present,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_play_valid,
   output logic [fjb_pkg::KEY_W-1:0]     rsp_play_frame,
   output logic [5:0]                    rsp_fill_count,
   output logic signed [31:0]            rsp_current_frame,
   output fjb_pkg::mem_req_type          mem_req,
   input  wire  [fjb_pkg::KEY_W-1:0]     rd_data
);
   import fjb_pkg::*;

   typedef enum logic [17:0] {
      S_IDLE     = 18'b000000000000000001,
      S_INS_RD   = 18'b000000000000000010,
      S_INS_CMP  = 18'b000000000000000100,
      S_SHF_RD   = 18'b000000000000001000,
      S_SHF_WR   = 18'b000000000000010000,
      S_EVICT    = 18'b000000000000100000,
      S_TRY      = 18'b000000000001000000,
      S_CH_LAST  = 18'b000000000010000000,
      S_CH_RD    = 18'b000000000100000000,
      S_CH_CMP   = 18'b000000001000000000,
      S_FB_RD    = 18'b000000010000000000,
      S_FB_WAIT  = 18'b000000100000000000,
      S_PLAY     = 18'b000001000000000000,
      S_RS_START = 18'b000010000000000000,
      S_RS_LAST  = 18'b000100000000000000,
      S_RS_RD    = 18'b001000000000000000,
      S_RS_CMP   = 18'b010000000000000000,
      S_FIN      = 18'b100000000000000000
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        base_ff, base_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [KEY_W-1:0]         prev_ff, prev_in;
   logic [KEY_W-1:0]         sel_ff, sel_in;
   logic signed [32:0]       lo_ff, lo_in;
   logic signed [31:0]       target_ff, target_in;
   logic signed [31:0]       pb_ff, pb_in;
   logic                     on_ff, on_in;
   logic [PLAYED_W-1:0]      played_ff, played_in;
   logic                     issue_ff, issue_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_pv_ff, out_pv_in;
   logic [KEY_W-1:0]         out_pf_ff, out_pf_in;
   logic [5:0]               out_fc_ff, out_fc_in;
   logic signed [31:0]       out_cf_ff, out_cf_in;

   logic [CNT_W-1:0]         cap_eff;
   logic [DLY_W-1:0]         dly_eff;

   always_comb begin
      if (cfg.capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(cfg.capacity) > CNT_W'(MAX_FRAMES)) begin
         cap_eff = CNT_W'(MAX_FRAMES);
      end else begin
         cap_eff = CNT_W'(cfg.capacity);
      end
      if (played_ff < PLAYED_LIMIT && cfg.delay_frames > DLY_CAP) begin
         dly_eff = DLY_CAP;
      end else if (cfg.delay_frames == '0) begin
         dly_eff = DLY_W'(1);
      end else begin
         dly_eff = cfg.delay_frames;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      prev_in      = prev_ff;
      sel_in       = sel_ff;
      lo_in        = lo_ff;
      target_in    = target_ff;
      pb_in        = pb_ff;
      on_in        = on_ff;
      played_in    = played_ff;
      issue_in     = issue_ff;
      rsp_valid_in = rsp_valid_ff;
      out_pv_in    = out_pv_ff;
      out_pf_in    = out_pf_ff;
      out_fc_in    = out_fc_ff;
      out_cf_in    = out_cf_ff;
      mem_req      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               key_in   = req_frame_number;
               issue_in = 1'b0;
               idx_in   = count_ff;
               case (req_cmd)
                  CMD_ADD: begin
                     if (!req_data_present) begin
                        state_in = S_FIN;
                     end else if (count_ff == '0) begin
                        pos_in   = '0;
                        idx_in   = '0;
                        state_in = S_SHF_RD;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_DONE: state_in = S_TRY;
                  CMD_RESYNC: state_in = (count_ff == '0) ? S_FIN : S_RS_START;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_INS_RD: begin
            mem_req.rd_addr = base_ff + ADDR_W'(idx_ff - CNT_W'(1));
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (rd_data == key_ff) begin
               state_in = S_EVICT;
            end else if (rd_data > key_ff) begin
               idx_in = idx_ff - CNT_W'(1);
               if (idx_ff == CNT_W'(1)) begin
                  pos_in   = '0;
                  idx_in   = count_ff;
                  state_in = S_SHF_RD;
               end else begin
                  state_in = S_INS_RD;
               end
            end else begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = S_SHF_RD;
            end
         end
         S_SHF_RD: begin
            if (idx_ff == pos_ff) begin
               mem_req.we      = 1'b1;
               mem_req.wr_addr = base_ff + ADDR_W'(pos_ff);
               mem_req.wr_data = key_ff;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_EVICT;
            end else begin
               mem_req.rd_addr = base_ff + ADDR_W'(idx_ff - CNT_W'(1));
               state_in        = S_SHF_WR;
            end
         end
         S_SHF_WR: begin
            mem_req.we      = 1'b1;
            mem_req.wr_addr = base_ff + ADDR_W'(idx_ff);
            mem_req.wr_data = rd_data;
            idx_in          = idx_ff - CNT_W'(1);
            state_in        = S_SHF_RD;
         end
         S_EVICT: begin
            if (count_ff > cap_eff) begin
               base_in  = base_ff + ADDR_W'(count_ff - cap_eff);
               count_in = cap_eff;
            end
            if (!on_ff) begin
               on_in = 1'b1;
               pb_in = $signed({1'b0, key_ff});
            end
            state_in = S_TRY;
         end
         S_TRY: begin
            mem_req.rd_addr = base_ff + ADDR_W'(count_ff - CNT_W'(1));
            idx_in          = count_ff - CNT_W'(2);
            state_in        = (on_ff && count_ff >= MIN_SELECT) ? S_CH_LAST : S_FIN;
         end
         S_CH_LAST: begin
            prev_in  = rd_data;
            state_in = S_CH_RD;
         end
         S_CH_RD: begin
            mem_req.rd_addr = base_ff + ADDR_W'(idx_ff);
            state_in        = S_CH_CMP;
         end
         S_CH_CMP: begin
            if (prev_ff == rd_data + KEY_W'(1)) begin
               sel_in   = rd_data;
               state_in = S_PLAY;
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff - CNT_W'(1);
               state_in = (idx_ff == '0) ? S_FB_RD : S_CH_RD;
            end
         end
         S_FB_RD: begin
            mem_req.rd_addr = (count_ff > BACK_OFFSET)
                            ? base_ff + ADDR_W'(count_ff - BACK_OFFSET) : base_ff;
            state_in = S_FB_WAIT;
         end
         S_FB_WAIT: begin
            sel_in   = rd_data;
            state_in = S_PLAY;
         end
         S_PLAY: begin
            if ($signed({1'b0, sel_ff}) != pb_ff) begin
               pb_in    = $signed({1'b0, sel_ff});
               issue_in = 1'b1;
               if (played_ff < PLAYED_LIMIT) begin
                  played_in = played_ff + PLAYED_W'(1);
               end
            end
            state_in = S_FIN;
         end
         S_RS_START: begin
            mem_req.rd_addr = base_ff + ADDR_W'(count_ff - CNT_W'(1));
            state_in        = S_RS_LAST;
         end
         S_RS_LAST: begin
            lo_in     = $signed({2'b00, rd_data}) - $signed({22'd0, dly_eff, 1'b0});
            target_in = $signed({1'b0, rd_data}) - $signed({22'd0, dly_eff});
            idx_in    = '0;
            n_in      = '0;
            state_in  = S_RS_RD;
         end
         S_RS_RD: begin
            mem_req.rd_addr = base_ff + ADDR_W'(idx_ff);
            state_in        = S_RS_CMP;
         end
         S_RS_CMP: begin
            if ($signed({2'b00, rd_data}) >= lo_ff) begin
               mem_req.we      = 1'b1;
               mem_req.wr_addr = base_ff + ADDR_W'(n_ff);
               mem_req.wr_data = rd_data;
               n_in            = n_ff + CNT_W'(1);
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff + CNT_W'(1) == count_ff) begin
               count_in = n_in;
               pb_in    = target_ff;
               state_in = S_FIN;
            end else begin
               state_in = S_RS_RD;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_pv_in    = issue_ff;
               out_pf_in    = issue_ff ? sel_ff : '0;
               out_fc_in    = 6'(count_ff);
               out_cf_in    = pb_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         pb_ff        <= '0;
         on_ff        <= 1'b0;
         played_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         pb_ff        <= pb_in;
         on_ff        <= on_in;
         played_ff    <= played_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      n_ff      <= n_in;
      prev_ff   <= prev_in;
      sel_ff    <= sel_in;
      lo_ff     <= lo_in;
      target_ff <= target_in;
      issue_ff  <= issue_in;
      out_pv_ff <= out_pv_in;
      out_pf_ff <= out_pf_in;
      out_fc_ff <= out_fc_in;
      out_cf_ff <= out_cf_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_play_valid    = out_pv_ff;
   assign rsp_play_frame    = out_pf_ff;
   assign rsp_fill_count    = out_fc_ff;
   assign rsp_current_frame = out_cf_ff;

endmodule
`default_nettype wire
